### rtl/jog_joystick_stepper_pulser_defines.svh
// assertion macros for the jog joystick stepper pulser
`ifndef JOG_JOYSTICK_STEPPER_PULSER_DEFINES_SVH
`define JOG_JOYSTICK_STEPPER_PULSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define JJSP_ASSERT_NOW(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |-> (cond_b)) else $error(msg);

// next-cycle implication, checked outside reset
`define JJSP_ASSERT_NEXT(label, cond_a, cond_b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |=> (cond_b)) else $error(msg);

`endif

### rtl/jjsp_pkg.sv
`default_nettype none

package jjsp_pkg;

    localparam int KEY_COUNT  = 12;
    localparam int COUNT_BITS = 14;
    localparam int SCAN_BITS  = 10;
    localparam int AXES       = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 14;

    // speed command per axis
    typedef enum logic [1:0] {
        SPEED_STOP   = 2'd0,
        SPEED_SLOW   = 2'd1,
        SPEED_MIDDLE = 2'd2,
        SPEED_FAST   = 2'd3
    } cmd_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SLOW_INTERVAL   = 2'd0,
        REG_MIDDLE_INTERVAL = 2'd1,
        REG_FAST_INTERVAL   = 2'd2,
        REG_SCAN_INTERVAL   = 2'd3
    } cfg_reg_t;

    localparam logic [COUNT_BITS-1:0] STOP_HOLD = COUNT_BITS'(9999);

    localparam logic [COUNT_BITS-1:0] SLOW_RESET   = COUNT_BITS'(30);
    localparam logic [COUNT_BITS-1:0] MIDDLE_RESET = COUNT_BITS'(12);
    localparam logic [COUNT_BITS-1:0] FAST_RESET   = COUNT_BITS'(6);
    localparam logic [SCAN_BITS-1:0]  SCAN_RESET   = SCAN_BITS'(50);

    // direction request given by the first direction key of each axis (x, y, z)
    localparam logic [AXES-1:0] FIRST_DIR = 3'b110;

endpackage

`default_nettype wire

### rtl/jjsp_if.sv
`default_nettype none

// input channel: one beat per tick
interface jjsp_keys_if
    import jjsp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KEY_COUNT-1:0] keys_raw;

    modport source (output valid, output keys_raw, input ready);
    modport sink   (input valid, input keys_raw, output ready);
endinterface

// result channel: step and direction levels
interface jjsp_result_if;
    logic valid;
    logic ready;
    logic step_x;
    logic dir_x;
    logic step_y;
    logic dir_y;
    logic step_z;
    logic dir_z;

    modport source (output valid, output step_x, output dir_x, output step_y,
                    output dir_y, output step_z, output dir_z, input ready);
    modport sink   (input valid, input step_x, input dir_x, input step_y,
                    input dir_y, input step_z, input dir_z, output ready);
endinterface

// configuration write channel
interface jjsp_cfg_if
    import jjsp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/jog_joystick_stepper_pulser.sv
`default_nettype none

// Jog joystick stepper pulser. Each beat on keys is one 0.1 ms tick with twelve
// active-low jog keys; each tick gives exactly one result beat carrying the step
// and direction levels of the X, Y and Z axes after that tick. A tick is taken
// every clock cycle and its result appears in the next cycle: the axis counters,
// the debounce and the decode all settle combinationally between the state
// registers, which double as the result register. Ticks stall only while a
// result waits on result.ready. Keys are scanned on the first tick and then on
// every scan_interval-th tick; a key counts as pressed only when it reads low on
// two scans in a row. Configuration writes are taken on any cycle and should be
// made while no tick is in flight.
`include "jog_joystick_stepper_pulser_defines.svh"

module jog_joystick_stepper_pulser
    import jjsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    jjsp_keys_if.sink    keys,
    jjsp_result_if.source result,
    jjsp_cfg_if.sink     cfg
);

    // configuration registers
    logic [COUNT_BITS-1:0] slow_interval_reg;
    logic [COUNT_BITS-1:0] middle_interval_reg;
    logic [COUNT_BITS-1:0] fast_interval_reg;
    logic [SCAN_BITS-1:0]  scan_interval_reg;

    // tick state
    logic [SCAN_BITS-1:0]  scan_phase_reg, scan_phase_next;
    logic [KEY_COUNT-1:0]  key_prev_reg, key_prev_next;
    cmd_t                  cmd_reg [AXES];
    cmd_t                  cmd_next [AXES];
    cmd_t                  cmd_prev_reg [AXES];
    cmd_t                  cmd_prev_next [AXES];
    logic [COUNT_BITS-1:0] count_reg [AXES];
    logic [COUNT_BITS-1:0] count_next [AXES];
    logic [AXES-1:0]       dir_req_reg, dir_req_next;
    logic [AXES-1:0]       dir_reg, dir_next;
    logic [AXES-1:0]       step_reg, step_next;
    logic                  out_valid_reg;

    logic keys_fire;

    assign keys.ready = !out_valid_reg || result.ready;
    assign keys_fire  = keys.valid && keys.ready;
    assign cfg.ready  = 1'b1;

    // reload value for a command
    function automatic logic [COUNT_BITS-1:0] interval_of(
        input cmd_t                  c,
        input logic [COUNT_BITS-1:0] slow_i,
        input logic [COUNT_BITS-1:0] mid_i,
        input logic [COUNT_BITS-1:0] fast_i
    );
        logic [COUNT_BITS-1:0] r;
        case (c)
            SPEED_SLOW:   r = slow_i;
            SPEED_MIDDLE: r = mid_i;
            SPEED_FAST:   r = fast_i;
            default:      r = STOP_HOLD;
        endcase
        return r;
    endfunction

    // axis countdowns, then key scan and decode
    always_comb
    begin
        logic [COUNT_BITS-1:0] count_mid;
        logic [KEY_COUNT-1:0]  pressed;
        logic                  d0, d1, s0, s1;
        logic [SCAN_BITS:0]    phase_inc;
        logic [SCAN_BITS-1:0]  period;

        scan_phase_next = scan_phase_reg;
        key_prev_next   = key_prev_reg;
        dir_req_next    = dir_req_reg;
        dir_next        = dir_reg;
        step_next       = step_reg;
        pressed         = ~(keys.keys_raw | key_prev_reg);
        phase_inc       = {1'b0, scan_phase_reg} + 1'b1;
        period          = (scan_interval_reg == '0) ? SCAN_BITS'(1) : scan_interval_reg;

        for (int a = 0; a < AXES; a++)
        begin
            // step countdown from the command in force before this tick
            count_mid = count_reg[a];
            if (cmd_reg[a] != cmd_prev_reg[a])
            begin
                count_mid = interval_of(cmd_reg[a], slow_interval_reg,
                                        middle_interval_reg, fast_interval_reg);
            end
            cmd_prev_next[a] = cmd_reg[a];
            if (cmd_reg[a] == SPEED_STOP)
            begin
                count_next[a] = STOP_HOLD;
            end
            else if (count_mid <= COUNT_BITS'(1))
            begin
                count_next[a] = interval_of(cmd_reg[a], slow_interval_reg,
                                            middle_interval_reg, fast_interval_reg);
                dir_next[a]   = dir_req_reg[a];
                step_next[a]  = ~step_reg[a];
            end
            else
            begin
                count_next[a] = count_mid - 1'b1;
            end

            // decode of the debounced keys on a scan tick
            cmd_next[a] = cmd_reg[a];
            d0 = pressed[4*a];
            d1 = pressed[4*a+1];
            s0 = pressed[4*a+2];
            s1 = pressed[4*a+3];
            if (scan_phase_reg == '0)
            begin
                cmd_next[a] = SPEED_STOP;
                if (d0 || d1)
                begin
                    if (s0 && s1)
                        cmd_next[a] = SPEED_FAST;
                    else if (s0)
                        cmd_next[a] = SPEED_SLOW;
                    else if (s1)
                        cmd_next[a] = SPEED_MIDDLE;
                    dir_req_next[a] = d0 ? FIRST_DIR[a] : ~FIRST_DIR[a];
                end
            end
        end

        if (scan_phase_reg == '0)
            key_prev_next = keys.keys_raw;

        // scan phase wraps at the scan interval
        if (phase_inc >= {1'b0, period})
            scan_phase_next = '0;
        else
            scan_phase_next = phase_inc[SCAN_BITS-1:0];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_interval_reg   <= SLOW_RESET;
            middle_interval_reg <= MIDDLE_RESET;
            fast_interval_reg   <= FAST_RESET;
            scan_interval_reg   <= SCAN_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_SLOW_INTERVAL:   slow_interval_reg   <= cfg.data;
                REG_MIDDLE_INTERVAL: middle_interval_reg <= cfg.data;
                REG_FAST_INTERVAL:   fast_interval_reg   <= cfg.data;
                REG_SCAN_INTERVAL:   scan_interval_reg   <= cfg.data[SCAN_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // tick state, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase_reg <= '0;
            key_prev_reg   <= '0;
            dir_req_reg    <= '0;
            dir_reg        <= '0;
            step_reg       <= '0;
            for (int a = 0; a < AXES; a++)
            begin
                cmd_reg[a]      <= SPEED_STOP;
                cmd_prev_reg[a] <= SPEED_STOP;
                count_reg[a]    <= '0;
            end
        end
        else if (keys_fire)
        begin
            scan_phase_reg <= scan_phase_next;
            key_prev_reg   <= key_prev_next;
            dir_req_reg    <= dir_req_next;
            dir_reg        <= dir_next;
            step_reg       <= step_next;
            for (int a = 0; a < AXES; a++)
            begin
                cmd_reg[a]      <= cmd_next[a];
                cmd_prev_reg[a] <= cmd_prev_next[a];
                count_reg[a]    <= count_next[a];
            end
        end
    end

    // result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (keys_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    assign result.valid  = out_valid_reg;
    assign result.step_x = step_reg[0];
    assign result.dir_x  = dir_reg[0];
    assign result.step_y = step_reg[1];
    assign result.dir_y  = dir_reg[1];
    assign result.step_z = step_reg[2];
    assign result.dir_z  = dir_reg[2];

    // checks
    `JJSP_ASSERT_NEXT(a_tick_gives_result, keys_fire, out_valid_reg, "tick without result")
    `JJSP_ASSERT_NEXT(a_no_phantom_result, !keys_fire && (!out_valid_reg || result.ready), !out_valid_reg, "result without tick")
    `JJSP_ASSERT_NEXT(a_phase_holds_idle, !keys_fire, $stable(scan_phase_reg), "scan phase moved without tick")
    `JJSP_ASSERT_NEXT(a_stopped_x_holds, keys_fire && cmd_reg[0] == SPEED_STOP, step_reg[0] == $past(step_reg[0]), "stopped axis stepped")
    `JJSP_ASSERT_NOW(a_phase_in_range, keys_fire && scan_interval_reg > SCAN_BITS'(1) && scan_phase_reg < scan_interval_reg, scan_phase_next < scan_interval_reg, "scan phase past interval")

endmodule

`default_nettype wire

### dv/tb_jog_joystick_stepper_pulser.sv
`default_nettype none

module tb_jog_joystick_stepper_pulser;
    import jjsp_pkg::*;

    // step and direction levels of one result beat, x axis first
    typedef struct packed {
        logic step_x;
        logic dir_x;
        logic step_y;
        logic dir_y;
        logic step_z;
        logic dir_z;
    } levels_t;

    logic clk = 1'b0;
    logic rst_n;

    jjsp_keys_if   keys_bus ();
    jjsp_result_if result_bus ();
    jjsp_cfg_if    cfg_bus ();

    jog_joystick_stepper_pulser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // pending key ticks and expected levels
    logic [KEY_COUNT-1:0] jog_q [$];
    levels_t              levels_q [$];
    int                   fail_count = 0;
    logic                 calm = 1'b0;

    // predictor copy of the registers
    logic [COUNT_BITS-1:0] slow_ticks   = SLOW_RESET;
    logic [COUNT_BITS-1:0] middle_ticks = MIDDLE_RESET;
    logic [COUNT_BITS-1:0] fast_ticks   = FAST_RESET;
    logic [SCAN_BITS-1:0]  scan_ticks   = SCAN_RESET;

    // predictor copy of the state
    int                    phase_m = 0;
    logic [KEY_COUNT-1:0]  keys_last = '0;
    cmd_t                  cmd_now [AXES] = '{SPEED_STOP, SPEED_STOP, SPEED_STOP};
    cmd_t                  cmd_was [AXES] = '{SPEED_STOP, SPEED_STOP, SPEED_STOP};
    logic [COUNT_BITS-1:0] count_m [AXES] = '{'0, '0, '0};
    logic [AXES-1:0]       dir_req  = '0;
    logic [AXES-1:0]       dir_lvl  = '0;
    logic [AXES-1:0]       step_lvl = '0;

    function automatic logic [COUNT_BITS-1:0] reload_for(input cmd_t c);
        case (c)
            SPEED_SLOW:   return slow_ticks;
            SPEED_MIDDLE: return middle_ticks;
            SPEED_FAST:   return fast_ticks;
            default:      return STOP_HOLD;
        endcase
    endfunction

    // one tick: axis countdowns, then scan and decode on the scan phase
    function automatic levels_t advance_tick(input logic [KEY_COUNT-1:0] keys);
        logic [KEY_COUNT-1:0] pressed;
        logic                 d0, d1, s0, s1;
        int                   period;
        period = (scan_ticks == '0) ? 1 : int'(scan_ticks);
        for (int a = 0; a < AXES; a++)
        begin
            if (cmd_now[a] != cmd_was[a])
                count_m[a] = reload_for(cmd_now[a]);
            cmd_was[a] = cmd_now[a];
            if (cmd_now[a] == SPEED_STOP)
                count_m[a] = STOP_HOLD;
            else if (count_m[a] <= 1)
            begin
                count_m[a]  = reload_for(cmd_now[a]);
                dir_lvl[a]  = dir_req[a];
                step_lvl[a] = ~step_lvl[a];
            end
            else
                count_m[a] = count_m[a] - 1'b1;
        end
        if (phase_m == 0)
        begin
            // pressed only when low on this scan and the previous one
            pressed   = ~(keys | keys_last);
            keys_last = keys;
            for (int a = 0; a < AXES; a++)
            begin
                d0 = pressed[4*a];
                d1 = pressed[4*a+1];
                s0 = pressed[4*a+2];
                s1 = pressed[4*a+3];
                cmd_now[a] = SPEED_STOP;
                if (d0 || d1)
                begin
                    if (s0 && s1)
                        cmd_now[a] = SPEED_FAST;
                    else if (s0)
                        cmd_now[a] = SPEED_SLOW;
                    else if (s1)
                        cmd_now[a] = SPEED_MIDDLE;
                    dir_req[a] = d0 ? FIRST_DIR[a] : ~FIRST_DIR[a];
                end
            end
        end
        phase_m = phase_m + 1;
        if (phase_m >= period)
            phase_m = 0;
        return '{step_lvl[0], dir_lvl[0], step_lvl[1], dir_lvl[1], step_lvl[2], dir_lvl[2]};
    endfunction

    task automatic store_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_SLOW_INTERVAL:   slow_ticks   = value[COUNT_BITS-1:0];
            REG_MIDDLE_INTERVAL: middle_ticks = value[COUNT_BITS-1:0];
            REG_FAST_INTERVAL:   fast_ticks   = value[COUNT_BITS-1:0];
            REG_SCAN_INTERVAL:   scan_ticks   = value[SCAN_BITS-1:0];
            default: ;
        endcase
    endtask

    // one register write; valid stays high for the next write
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        store_reg(idx, value);
    endtask

    task automatic drain();
        while (jog_q.size() != 0 || keys_bus.valid || levels_q.size() != 0)
            @(posedge clk);
    endtask

    // wait for idle, then write all four registers
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] slow, middle, fast, scan);
        drain();
        repeat (2) @(posedge clk);
        write_reg(REG_SLOW_INTERVAL, slow);
        write_reg(REG_MIDDLE_INTERVAL, middle);
        write_reg(REG_FAST_INTERVAL, fast);
        write_reg(REG_SCAN_INTERVAL, scan);
        cfg_bus.valid <= 1'b0;
    endtask

    // a jog gesture: per axis none, one or both direction keys, any speed keys
    function automatic logic [KEY_COUNT-1:0] jog_pattern();
        logic [KEY_COUNT-1:0] pressed;
        int                   sel;
        pressed = '0;
        for (int a = 0; a < AXES; a++)
        begin
            sel = $urandom_range(0, 9);
            pressed[4*a]   = (sel >= 1 && sel <= 4) || sel == 9;
            pressed[4*a+1] = sel >= 5;
            pressed[4*a+2] = 1'($urandom_range(0, 1));
            pressed[4*a+3] = 1'($urandom_range(0, 1));
        end
        return ~pressed;
    endfunction

    // gestures held for a random run of ticks, with some bit noise
    task automatic queue_jog(input int count);
        logic [KEY_COUNT-1:0] pat;
        int                   left;
        int                   run;
        int                   period;
        left   = count;
        period = (scan_ticks == '0) ? 1 : int'(scan_ticks);
        while (left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                pat = KEY_COUNT'($urandom_range(0, 4095));
            else
                pat = jog_pattern();
            run = $urandom_range(1, (period > 100) ? 300 : 3 * period + 8);
            for (int i = 0; i < run && left > 0; i++)
            begin
                if ($urandom_range(0, 99) < 10)
                    jog_q.push_back(pat ^ (12'h001 << $urandom_range(0, KEY_COUNT - 1)));
                else
                    jog_q.push_back(pat);
                left--;
            end
        end
    endtask

    // key driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_bus.valid    <= 1'b0;
            keys_bus.keys_raw <= '1;
        end
        else
        begin
            if (keys_bus.valid && keys_bus.ready)
                levels_q.push_back(advance_tick(keys_bus.keys_raw));
            if (!keys_bus.valid || keys_bus.ready)
            begin
                if (jog_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25))
                begin
                    keys_bus.valid    <= 1'b1;
                    keys_bus.keys_raw <= jog_q.pop_front();
                end
                else
                    keys_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        levels_t      got;
        levels_t      want;
        string        field_name [6];
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                field_name = '{"step_x", "dir_x", "step_y", "dir_y", "step_z", "dir_z"};
                got = '{result_bus.step_x, result_bus.dir_x, result_bus.step_y,
                        result_bus.dir_y, result_bus.step_z, result_bus.dir_z};
                if (levels_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %b", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = levels_q.pop_front();
                    for (int i = 0; i < 6; i++)
                        if (got[5-i] !== want[5-i])
                        begin
                            $display("%0t: %s expected %b actual %b",
                                     $time, field_name[i], want[5-i], got[5-i]);
                            fail_count++;
                        end
                end
            end
            result_bus.ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n             <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= REG_SLOW_INTERVAL;
        cfg_bus.data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // first scan at reset settings: keys read as pressed before it
        jog_q.push_back(12'h000);
        jog_q.push_back(12'hFFF);

        // directed gestures, scanning every tick
        set_config(14'd3, 14'd2, 14'd1, 14'd1);
        repeat (3) jog_q.push_back(12'h000);  // all keys, fast, first directions
        repeat (3) jog_q.push_back(12'hFFA);  // left with x1: x slow
        repeat (3) jog_q.push_back(12'hFF5);  // right with x2: x middle
        repeat (3) jog_q.push_back(12'hF2F);  // up with y1 and y2: y fast
        repeat (3) jog_q.push_back(12'hF9F);  // down with y1: y slow
        repeat (3) jog_q.push_back(12'h6FF);  // zup with z2: z middle
        repeat (3) jog_q.push_back(12'h1FF);  // zdown with z1 and z2: z fast
        repeat (3) jog_q.push_back(12'hFFF);  // all released: stop

        // zero interval toggles every tick, longest interval never does
        set_config(14'd0, 14'd1, 14'd16383, 14'd1);
        queue_jog(250);

        // no idling on either side
        set_config(14'd5, 14'd3, 14'd2, 14'd3);
        calm = 1'b1;
        queue_jog(300);
        drain();
        calm = 1'b0;

        // longest scan interval
        set_config(14'd1, 14'd16383, 14'd0, 14'd1023);
        queue_jog(200);

        // zero scan interval, phase left beyond it wraps
        set_config(14'd16383, 14'd7, 14'd4, 14'd0);
        queue_jog(250);

        // upper data bits on the scan register are dropped
        set_config(14'd9, 14'd5, 14'd2, 14'h3C28);
        queue_jog(230);

        // shortened scan interval mid-phase
        set_config(14'd4, 14'd2, 14'd1, 14'd2);
        queue_jog(250);

        set_config(14'($urandom_range(1, 30)), 14'($urandom_range(1, 30)),
                   14'($urandom_range(1, 30)), 14'($urandom_range(1, 8)));
        queue_jog(250);

        // back to the reset settings
        set_config(SLOW_RESET, MIDDLE_RESET, FAST_RESET, 14'(SCAN_RESET));
        queue_jog(300);

        drain();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
